FILE: sv/chmap_pkg.sv
// Shared types and codes of the chained hash map engine.
package chmap_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_GET_ALT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_OVERWRITTEN = 2'd1,
    ST_ABSENT      = 2'd2,
    ST_FULL        = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_HEAD,
    S_RDNODE,
    S_CMP,
    S_ACT,
    S_FREERD,
    S_LINK,
    S_DONE
  } state_t;

  localparam logic [6:0] BUCKET_COUNT_RESET = 7'd64;
  localparam int KEY_W = 64;
  localparam int MOD_STEPS = 64;

  typedef struct packed {
    logic start;
  } mod_ctl_t;

endpackage

FILE: sv/chmap_mod.sv
// Bit-serial unit that reduces a 64-bit key modulo the bucket count.
module chmap_mod (
  input  logic                    clk,
  input  logic                    rst,
  input  chmap_pkg::mod_ctl_t     ctl,
  input  logic [63:0]             key,
  input  logic [6:0]              divisor,
  output logic                    done,
  output logic [6:0]              remainder
);
  import chmap_pkg::*;

  logic [63:0] shreg;
  logic [7:0]  rem;
  logic [6:0]  cnt;
  logic        running;
  logic [7:0]  trial;

  assign trial = {rem[6:0], shreg[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        running <= 1'b1;
        cnt     <= '0;
        shreg   <= key;
        rem     <= '0;
      end else if (running) begin
        shreg <= {shreg[62:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem <= trial - {1'b0, divisor};
        end else begin
          rem <= trial;
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'(MOD_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[6:0];

  always_ff @(posedge clk) begin
    if (!rst && done) begin
      assert (rem[6:0] < divisor) else $error("remainder not below divisor");
    end
  end

endmodule

FILE: sv/chained_hash_map_engine_unit.sv
// Top level of the chained hash map engine.
// After an item is accepted the engine reduces the key, reads the bucket head, compares each
// node of the chain in turn, notes the end of the chain and then does the update.
// One item is in work at a time; the next is accepted only after the result is taken and the
// engine is back in idle. Synchronous active-high reset clears a valid bit per bucket head at
// once and clears the counters; node storage is not cleared.
module chained_hash_map_engine_unit #(
  parameter int MAX_BUCKETS = 64,
  parameter int POOL_NODES  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [63:0] key,
  input  logic [63:0] data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] data_out,
  output logic [$clog2(POOL_NODES+1)-1:0] entry_count
);
  import chmap_pkg::*;

  localparam int NW = $clog2(POOL_NODES + 1);
  localparam int IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam logic [NW-1:0] NULL_NODE = NW'(POOL_NODES);

  logic [6:0] bucket_count;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      bucket_count <= pwdata[6:0];
    end
  end
  assign prdata = (paddr[2] == 1'b0) ? {25'd0, bucket_count} : 32'd0;

  logic [6:0] divisor;
  always_comb begin
    divisor = bucket_count;
    if (divisor == 7'd0) divisor = 7'd1;
    if (32'(divisor) > MAX_BUCKETS) divisor = 7'(MAX_BUCKETS);
  end

  logic [NW-1:0] head_mem [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] head_vld;
  logic [63:0] nkey_mem [POOL_NODES];
  logic [63:0] ndata_mem [POOL_NODES];
  logic [NW-1:0] nnext_mem [POOL_NODES];
  logic [IW-1:0] free_mem [POOL_NODES];

  state_t state, state_next;
  logic [1:0]  cmd_r;
  logic [63:0] key_r, data_r;
  logic [BW-1:0] bkt;
  logic [BW-1:0] head_addr;
  logic [NW-1:0] cur, prev, hit;
  logic [NW-1:0] free_top, fresh_wm, stored;
  logic [NW-1:0] steps;
  logic [63:0] rd_key, rd_data;
  logic [NW-1:0] rd_next, head_rd;
  logic [IW-1:0] free_rd;
  logic [NW-1:0] fresh;
  logic [1:0]  st_r;
  logic [63:0] dout_r;

  mod_ctl_t mctl;
  logic mdone;
  logic [6:0] mrem;

  chmap_mod u_mod (
    .clk(clk), .rst(rst), .ctl(mctl), .key(key_r), .divisor(divisor),
    .done(mdone), .remainder(mrem)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    mctl.start = 1'b0;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_MOD;
      S_MOD: if (mdone) state_next = S_HEAD;
      S_HEAD: state_next = S_RDNODE;
      S_RDNODE: begin
        if (cur >= NULL_NODE || steps >= NW'(POOL_NODES)) state_next = S_ACT;
        else state_next = S_CMP;
      end
      S_CMP: begin
        if (rd_key == key_r) state_next = S_ACT;
        else state_next = S_RDNODE;
      end
      S_ACT: begin
        if (cmd_r == CMD_INSERT && hit >= NULL_NODE && free_top != '0)
          state_next = S_FREERD;
        else if (cmd_r == CMD_INSERT && hit >= NULL_NODE) state_next = S_LINK;
        else state_next = S_DONE;
      end
      S_FREERD: state_next = S_LINK;
      S_LINK: state_next = S_DONE;
      S_DONE: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (state == S_IDLE && in_valid) mctl.start = 1'b0;
    if (state == S_MOD && !mdone && steps == NW'(1)) mctl.start = 1'b1;
  end

  assign head_addr = (state == S_MOD) ? BW'(mrem) : bkt;

  // memory reads
  always_ff @(posedge clk) begin
    head_rd <= head_vld[head_addr] ? head_mem[head_addr] : NULL_NODE;
    rd_key  <= nkey_mem[cur[IW-1:0]];
    rd_data <= ndata_mem[cur[IW-1:0]];
    rd_next <= nnext_mem[cur[IW-1:0]];
    free_rd <= free_mem[IW'(free_top - NW'(1))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= '0;
      free_top <= '0;
      fresh_wm <= '0;
      stored   <= '0;
      steps    <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          cmd_r  <= command;
          key_r  <= key;
          data_r <= data_in;
          steps  <= NW'(1);
        end
        S_MOD: begin
          steps <= '0;
          if (mdone) bkt <= BW'(mrem);
        end
        S_HEAD: begin
          cur  <= head_rd;
          prev <= NULL_NODE;
          hit  <= NULL_NODE;
        end
        S_RDNODE: ;
        S_CMP: begin
          if (rd_key == key_r) begin
            hit <= cur;
          end else begin
            prev  <= cur;
            cur   <= rd_next;
            steps <= steps + NW'(1);
          end
        end
        S_ACT: begin
          if (cmd_r == CMD_INSERT) begin
            dout_r <= '0;
            if (hit < NULL_NODE) begin
              ndata_mem[hit[IW-1:0]] <= data_r;
              st_r <= ST_OVERWRITTEN;
            end else begin
              st_r <= ST_OK;
              if (free_top == '0) begin
                if (fresh_wm < NW'(POOL_NODES)) begin
                  fresh    <= fresh_wm;
                  fresh_wm <= fresh_wm + NW'(1);
                end else begin
                  fresh <= NULL_NODE;
                end
              end
            end
          end else if (cmd_r == CMD_REMOVE) begin
            dout_r <= '0;
            if (hit < NULL_NODE) begin
              st_r <= ST_OK;
              if (prev < NULL_NODE) nnext_mem[prev[IW-1:0]] <= rd_next;
              else begin
                head_mem[bkt] <= rd_next;
                head_vld[bkt] <= 1'b1;
              end
              if (free_top < NW'(POOL_NODES)) begin
                free_mem[free_top[IW-1:0]] <= hit[IW-1:0];
                free_top <= free_top + NW'(1);
              end
              if (stored != '0) stored <= stored - NW'(1);
            end else st_r <= ST_ABSENT;
          end else begin
            if (hit < NULL_NODE) begin
              dout_r <= rd_data;
              st_r   <= ST_OK;
            end else begin
              dout_r <= '0;
              st_r   <= ST_ABSENT;
            end
          end
        end
        S_FREERD: begin
          free_top <= free_top - NW'(1);
          fresh    <= NW'(free_rd);
        end
        S_LINK: begin
          if (fresh < NULL_NODE) begin
            nkey_mem[fresh[IW-1:0]]  <= key_r;
            ndata_mem[fresh[IW-1:0]] <= data_r;
            nnext_mem[fresh[IW-1:0]] <= head_rd;
            head_mem[bkt] <= fresh;
            head_vld[bkt] <= 1'b1;
            stored <= stored + NW'(1);
          end else st_r <= ST_FULL;
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

  assign status      = st_r;
  assign data_out    = dout_r;
  assign entry_count = stored;

  property p_in_out_excl;
    @(posedge clk) disable iff (rst) !(in_ready && out_valid);
  endproperty
  a_in_out_excl: assert property (p_in_out_excl) else $error("ready while result held");

  property p_stored_bound;
    @(posedge clk) disable iff (rst) stored <= fresh_wm;
  endproperty
  a_stored_bound: assert property (p_stored_bound) else $error("more entries than nodes");

  property p_free_bound;
    @(posedge clk) disable iff (rst) free_top <= fresh_wm;
  endproperty
  a_free_bound: assert property (p_free_bound) else $error("free stack overflow");

endmodule

FILE: tb/sv/chained_hash_map_engine_unit_tb.sv
// Self-checking testbench of the chained hash map engine with a map predictor.
`timescale 1ns / 100ps

module chained_hash_map_engine_unit_tb;
  import chmap_pkg::*;

  localparam int NODES = 256;
  localparam int HEADS = 64;
  localparam int NIL = NODES;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [2:0] ADDR_BUCKETS = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = CMD_INSERT;
  logic [63:0] key = '0;
  logic [63:0] data_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [63:0] data_out;
  logic [8:0] entry_count;

  always #2 clk = ~clk;

  chained_hash_map_engine_unit dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .key(key),
    .data_in(data_in), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .data_out(data_out), .entry_count(entry_count)
  );

  typedef struct {
    status_t st;
    logic [63:0] dout;
    logic [8:0] cnt;
  } lookup_result_t;

  logic [6:0] bucket_cfg = BUCKET_COUNT_RESET;
  int chain_head[HEADS];
  logic [63:0] node_key_m[NODES];
  logic [63:0] node_data_m[NODES];
  int node_next_m[NODES];
  int free_nodes[NODES];
  int free_depth = 0;
  int never_used = 0;
  int live_entries = 0;

  lookup_result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int full_seen = 0;
  int idle_cycles = 0;
  bit hold_receiver = 1'b0;
  logic [63:0] key_pool[48];

  initial begin
    for (int i = 0; i < HEADS; i++) chain_head[i] = NIL;
  end

  function automatic lookup_result_t predict_lookup(cmd_t c, logic [63:0] k,
                                                    logic [63:0] d);
    lookup_result_t r;
    int n, b, cur, prv, hit, steps, fresh;
    n = bucket_cfg;
    if (n == 0) n = 1;
    if (n > HEADS) n = HEADS;
    b = int'(k % 64'(n));
    cur = chain_head[b];
    prv = NIL;
    hit = NIL;
    steps = 0;
    while (cur < NIL && steps < NODES && hit == NIL) begin
      if (node_key_m[cur] == k) begin
        hit = cur;
      end else begin
        prv = cur;
        cur = node_next_m[cur];
      end
      steps++;
    end
    r.st = ST_OK;
    r.dout = '0;
    if (c == CMD_INSERT) begin
      if (hit < NIL) begin
        node_data_m[hit] = d;
        r.st = ST_OVERWRITTEN;
      end else begin
        fresh = NIL;
        if (free_depth > 0) begin
          free_depth--;
          fresh = free_nodes[free_depth];
        end else if (never_used < NODES) begin
          fresh = never_used;
          never_used++;
        end
        if (fresh < NIL) begin
          node_key_m[fresh] = k;
          node_data_m[fresh] = d;
          node_next_m[fresh] = chain_head[b];
          chain_head[b] = fresh;
          live_entries++;
        end else begin
          r.st = ST_FULL;
        end
      end
    end else if (c == CMD_REMOVE) begin
      if (hit < NIL) begin
        if (prv < NIL) node_next_m[prv] = node_next_m[hit];
        else chain_head[b] = node_next_m[hit];
        if (free_depth < NODES) begin
          free_nodes[free_depth] = hit;
          free_depth++;
        end
        if (live_entries > 0) live_entries--;
      end else begin
        r.st = ST_ABSENT;
      end
    end else begin
      if (hit < NIL) r.dout = node_data_m[hit];
      else r.st = ST_ABSENT;
    end
    r.cnt = 9'(live_entries);
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= 30)
      $display("mismatch on %s after %0d results: got %h, expected %h", what,
               results_seen, got, want);
  endtask

  task automatic send_command(cmd_t c, logic [63:0] k, logic [63:0] d);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command <= c;
    key <= k;
    data_in <= d;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_results.push_back(predict_lookup(c, k, d));
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] addr, logic [31:0] value);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_BUCKETS) bucket_cfg = value[6:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("chained_hash_map_engine_unit_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    lookup_result_t want;
    int stall;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (hold_receiver) stall = 300;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hold_receiver = 1'b0;
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      results_seen++;
      if (pending_results.size() == 0) begin
        report("unexpected result", {62'd0, status}, '0);
      end else begin
        want = pending_results.pop_front();
        if (status != want.st) report("status", {62'd0, status}, {62'd0, want.st});
        if (data_out != want.dout) report("data_out", data_out, want.dout);
        if (entry_count != want.cnt)
          report("entry_count", {55'd0, entry_count}, {55'd0, want.cnt});
        if (want.st == ST_FULL) full_seen++;
      end
    end
  end

  task automatic test_basic_commands();
    logic [63:0] top_key;
    top_key = '1;
    send_command(CMD_GET, 64'd0, '1);
    send_command(CMD_REMOVE, 64'd0, '0);
    send_command(CMD_INSERT, 64'd0, '1);
    send_command(CMD_INSERT, top_key, 64'h0);
    send_command(CMD_INSERT, 64'd64, 64'h5555_aaaa_5555_aaaa);
    send_command(CMD_INSERT, 64'd128, 64'haaaa_5555_aaaa_5555);
    send_command(CMD_GET, 64'd0, '0);
    send_command(CMD_GET_ALT, top_key, '1);
    send_command(CMD_GET, 64'd64, '0);
    send_command(CMD_INSERT, 64'd0, 64'h1234_5678_9abc_def0);
    send_command(CMD_GET, 64'd0, '0);
    send_command(CMD_REMOVE, 64'd64, '0);
    send_command(CMD_GET, 64'd64, '0);
    send_command(CMD_GET, 64'd128, '0);
    send_command(CMD_REMOVE, 64'd64, '0);
    send_command(CMD_INSERT, 64'd192, '1);
    send_command(CMD_REMOVE, 64'd0, '0);
    send_command(CMD_REMOVE, 64'd128, '0);
    send_command(CMD_REMOVE, 64'd192, '0);
    send_command(CMD_REMOVE, top_key, '0);
  endtask

  task automatic test_bucket_settings();
    write_register(ADDR_BUCKETS, 32'hffff_ff00);
    send_command(CMD_INSERT, 64'd7, 64'd70);
    send_command(CMD_INSERT, 64'd9, 64'd90);
    send_command(CMD_GET, 64'd7, '0);
    write_register(ADDR_BUCKETS, 32'd127);
    send_command(CMD_GET, 64'd7, '0);
    send_command(CMD_INSERT, 64'd71, 64'd710);
    write_register(ADDR_UNUSED, 32'd1);
    send_command(CMD_GET, 64'd71, '0);
    write_register(ADDR_BUCKETS, 32'd1);
    send_command(CMD_GET, 64'd9, '0);
    send_command(CMD_REMOVE, 64'd7, '0);
    send_command(CMD_REMOVE, 64'd9, '0);
    write_register(ADDR_BUCKETS, 32'd64);
    send_command(CMD_REMOVE, 64'd71, '0);
  endtask

  task automatic test_pool_exhaustion();
    for (int i = 0; i < NODES + 3; i++)
      send_command(CMD_INSERT, 64'(i) * 64'd1001, {$urandom, $urandom});
    send_command(CMD_INSERT, 64'd5005, '1);
    for (int i = 0; i < 12; i++)
      send_command(CMD_REMOVE, 64'(i * 3) * 64'd1001, '0);
    for (int i = 0; i < 14; i++)
      send_command(CMD_INSERT, 64'd900000 + 64'(i), {$urandom, $urandom});
    for (int i = 0; i < NODES + 3; i++)
      send_command(CMD_REMOVE, 64'(i) * 64'd1001, '0);
    for (int i = 0; i < 14; i++)
      send_command(CMD_REMOVE, 64'd900000 + 64'(i), '0);
  endtask

  task automatic test_random_traffic();
    logic [31:0] settings[6];
    int pick;
    cmd_t c;
    settings = '{32'd37, 32'd1, 32'd64, 32'd0, 32'd127, 32'd5};
    for (int i = 0; i < 48; i++) begin
      if (i < 8) key_pool[i] = 64'($urandom_range(0, 200));
      else key_pool[i] = {$urandom, $urandom};
    end
    for (int phase = 0; phase < 6; phase++) begin
      write_register(ADDR_BUCKETS, (($urandom_range(0, 1) != 0) ? ($urandom << 7) : 32'd0)
                     | settings[phase]);
      if (phase == 2) hold_receiver = 1'b1;
      for (int n = 0; n < 45; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 8) c = CMD_INSERT;
        else if (pick < 13) c = CMD_REMOVE;
        else if (pick < 18) c = CMD_GET;
        else c = CMD_GET_ALT;
        if ($urandom_range(0, 15) == 0)
          send_command(c, {$urandom, $urandom}, {$urandom, $urandom});
        else
          send_command(c, key_pool[$urandom_range(0, 47)], {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_basic_commands();
    test_bucket_settings();
    test_pool_exhaustion();
    test_random_traffic();
    drain_results();
    repeat (20) @(posedge clk);
    $display("Sent %0d commands and checked %0d results, %0d of them pool full,",
             items_sent, results_seen, full_seen);
    $display("over bucket counts from zero to saturated and a long output stall.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("chained_hash_map_engine_unit_tb OK");
    end else begin
      $display("chained_hash_map_engine_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/chmap_pkg.sv
sv/chmap_mod.sv
sv/chained_hash_map_engine_unit.sv
tb/sv/chained_hash_map_engine_unit_tb.sv
